### hw/rtl/ejd_pkg.sv
`default_nettype none

package ejd_pkg;

    localparam int TIME_W    = 16;
    localparam int LOAD_W    = 28;
    localparam int FIN_W     = LOAD_W + 1;
    localparam int JOBS_W    = 12;
    localparam int MULT_W    = 12;
    localparam int TOTAL_W   = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int STEP_W    = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_MULT  = 2'd1;

    typedef logic [STEP_W-1:0] t_step;

    // Microprogram step addresses.
    localparam t_step S_LOAD   = 4'd0;
    localparam t_step S_CLEAR  = 4'd1;
    localparam t_step S_JOB    = 4'd2;
    localparam t_step S_SCAN   = 4'd3;
    localparam t_step S_DRAIN  = 4'd4;
    localparam t_step S_UPDATE = 4'd5;
    localparam t_step S_PEAK   = 4'd6;
    localparam t_step S_PDRAIN = 4'd7;
    localparam t_step S_MUL    = 4'd8;
    localparam t_step S_EMIT   = 4'd9;

    typedef enum logic [2:0] {
        C_NEVER,     // fall through to the next step
        C_ALWAYS,    // unconditional jump
        C_LAST,      // marked item transferred on the input channel
        C_IDX_MORE,  // worker index has not reached the last worker
        C_NO_JOBS,   // no jobs left to hand out
        C_OUT_FREE   // output register can take a new result
    } t_cond;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_STEP     // increment while looping, clear on exit
    } t_idx_op;

    typedef struct packed {
        logic    accept;
        logic    clr_we;
        logic    ld_jobs;
        logic    rst_best;
        logic    rd_en;
        logic    peak_mode;
        logic    upd_we;
        logic    dec_jobs;
        logic    mul_en;
        logic    emit;
        t_idx_op idx_op;
        t_cond   cond;
        logic    stay;       // hold on this step while the condition is false
        t_step   target;
    } t_uop;

    function automatic t_uop ucode_rom(input t_step step);
        t_uop u;
        u.accept    = 1'b0;
        u.clr_we    = 1'b0;
        u.ld_jobs   = 1'b0;
        u.rst_best  = 1'b0;
        u.rd_en     = 1'b0;
        u.peak_mode = 1'b0;
        u.upd_we    = 1'b0;
        u.dec_jobs  = 1'b0;
        u.mul_en    = 1'b0;
        u.emit      = 1'b0;
        u.idx_op    = IDX_HOLD;
        u.cond      = C_NEVER;
        u.stay      = 1'b0;
        u.target    = S_LOAD;
        case (step)
            S_LOAD: begin
                u.accept = 1'b1;
                u.idx_op = IDX_CLR;
                u.cond   = C_LAST;
                u.stay   = 1'b1;
                u.target = S_CLEAR;
            end
            S_CLEAR: begin
                u.clr_we  = 1'b1;
                u.ld_jobs = 1'b1;
                u.idx_op  = IDX_STEP;
                u.cond    = C_IDX_MORE;
                u.target  = S_CLEAR;
            end
            S_JOB: begin
                u.rst_best = 1'b1;
                u.cond     = C_NO_JOBS;
                u.target   = S_PEAK;
            end
            S_SCAN: begin
                u.rd_en  = 1'b1;
                u.idx_op = IDX_STEP;
                u.cond   = C_IDX_MORE;
                u.target = S_SCAN;
            end
            S_DRAIN: begin
                u.cond = C_NEVER;
            end
            S_UPDATE: begin
                u.upd_we   = 1'b1;
                u.dec_jobs = 1'b1;
                u.cond     = C_ALWAYS;
                u.target   = S_JOB;
            end
            S_PEAK: begin
                u.rd_en     = 1'b1;
                u.peak_mode = 1'b1;
                u.idx_op    = IDX_STEP;
                u.cond      = C_IDX_MORE;
                u.target    = S_PEAK;
            end
            S_PDRAIN: begin
                u.cond = C_NEVER;
            end
            S_MUL: begin
                u.mul_en = 1'b1;
            end
            S_EMIT: begin
                u.emit   = 1'b1;
                u.cond   = C_OUT_FREE;
                u.stay   = 1'b1;
                u.target = S_LOAD;
            end
            default: begin
                u.cond   = C_ALWAYS;
                u.target = S_LOAD;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/earliest_finish_job_dispatch.sv
// Earliest-finish job dispatch over a set of workers.
// Input stream: each transfer carries one worker's per-job time in tdata; the
// transfer with tlast high ends the worker list and starts a run. Workers
// beyond MAX_WORKERS are dropped, but a dropped tlast still starts the run.
// During a run, job_count identical jobs are handed out one at a time, each
// to the worker whose finish time would be smallest (lowest index on a tie).
// The output stream then carries one transfer: the largest load times
// row_multiplier, 40 bits wide.
// Configuration: a separate write channel, always ready, with register index
// 0 for job_count and 1 for row_multiplier; write it only while idle.
// Throughput: worker items are taken one per cycle while a list is loading.
// A small microprogram sequences the run; the scan reads one worker per cycle
// from the time and load memories, so each job is a scan, a drain and an
// update step, and the load clear and final peak search sweep every worker.
// The input channel is not ready during a run. A result that the receiver
// stalls waits in the output register; the next worker list is taken
// meanwhile, and the next run only holds at its last step until it drains.
// Reset is synchronous and active low; it clears both registers, the worker
// count, the sequencer and the output valid flag.
`default_nettype none

module earliest_finish_job_dispatch #(
    parameter int MAX_WORKERS = 16,
    localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
    localparam int CW = $clog2(MAX_WORKERS + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Worker stream. tdata: job_time[15:0].
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [ejd_pkg::TIME_W-1:0]       i_s_axis_tdata,
    input  wire logic                             i_s_axis_tlast,
    // Result stream. tdata: total_time[39:0].
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic      [ejd_pkg::TOTAL_W-1:0]      o_m_axis_tdata,
    // Configuration write channel.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ejd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ejd_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    import ejd_pkg::*;

    // Sequencer and configuration state.
    t_step               r_pc, n_pc;
    t_uop                uop;
    logic [JOBS_W-1:0]   r_job_count;
    logic [MULT_W-1:0]   r_row_mult;

    // Worker bookkeeping.
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_last_idx;   // index of the final worker of the run
    logic [IW-1:0]       r_idx;
    logic [JOBS_W-1:0]   r_jobs_left;

    // Scan pipeline: memory read data is registered and returns in the cycle after the read.
    logic                r_rd_vld;
    logic                r_rd_peak;
    logic [IW-1:0]       r_rd_idx;
    logic                r_first;
    logic [FIN_W-1:0]    r_best_fin;
    logic [IW-1:0]       r_best_idx;
    logic [LOAD_W-1:0]   r_peak;
    logic [TOTAL_W-1:0]  r_prod;
    logic [TOTAL_W-1:0]  prod;

    // Output register.
    logic                r_out_vld;
    logic [TOTAL_W-1:0]  r_out_data;

    logic                in_xfer;
    logic                cond_true;
    logic                idx_more;
    logic                out_free;
    logic                time_we;
    logic                load_we;
    logic [IW-1:0]       load_waddr;
    logic [LOAD_W-1:0]   load_wdata;
    logic [TIME_W-1:0]   time_rdata;
    logic [LOAD_W-1:0]   load_rdata;
    logic [FIN_W-1:0]    fin;

    assign uop      = ucode_rom(r_pc);
    assign in_xfer  = i_s_axis_tvalid && uop.accept;
    assign idx_more = (r_idx != r_last_idx);
    assign out_free = !r_out_vld || i_m_axis_tready;

    assign o_s_axis_tready = uop.accept;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        case (uop.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_LAST:     cond_true = in_xfer && i_s_axis_tlast;
            C_IDX_MORE: cond_true = idx_more;
            C_NO_JOBS:  cond_true = (r_jobs_left == '0);
            C_OUT_FREE: cond_true = out_free;
            default:    cond_true = 1'b0;
        endcase
        if (cond_true) begin
            n_pc = uop.target;
        end else if (uop.stay) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    // Worker times are written only while the list is loading and only into
    // free slots; the load memory is cleared by the sweep or updated with the
    // winning finish time.
    assign time_we    = in_xfer && (r_count < CW'(MAX_WORKERS));
    assign load_we    = uop.clr_we || uop.upd_we;
    assign load_waddr = uop.upd_we ? r_best_idx : r_idx;
    assign load_wdata = uop.upd_we ? r_best_fin[LOAD_W-1:0] : '0;
    assign fin        = FIN_W'(load_rdata) + FIN_W'(time_rdata);
    assign prod       = TOTAL_W'(r_peak) * TOTAL_W'(r_row_mult);

    ejd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_WORKERS)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_re    (uop.rd_en),
        .i_raddr (r_idx),
        .o_rdata (time_rdata)
    );

    ejd_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (MAX_WORKERS)
    ) u_load_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_waddr),
        .i_wdata (load_wdata),
        .i_re    (uop.rd_en),
        .i_raddr (r_idx),
        .o_rdata (load_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_LOAD;
            r_job_count <= '0;
            r_row_mult  <= '0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_rd_vld <= uop.rd_en;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_JOB_COUNT: r_job_count <= i_cfg_data;
                    CFG_ROW_MULT:  r_row_mult  <= i_cfg_data;
                    default:       ;
                endcase
            end
            if (in_xfer) begin
                if (i_s_axis_tlast) begin
                    r_count <= '0;
                end else if (time_we) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (uop.emit && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_s_axis_tlast) begin
            r_last_idx <= time_we ? r_count[IW-1:0] : IW'(MAX_WORKERS - 1);
        end
        case (uop.idx_op)
            IDX_HOLD: ;
            IDX_CLR:  r_idx <= '0;
            IDX_STEP: r_idx <= idx_more ? r_idx + 1'b1 : '0;
            default:  ;
        endcase
        if (uop.ld_jobs) begin
            r_jobs_left <= r_job_count;
            r_peak      <= '0;
        end else if (uop.dec_jobs) begin
            r_jobs_left <= r_jobs_left - 1'b1;
        end
        r_rd_peak <= uop.peak_mode;
        r_rd_idx  <= r_idx;
        if (uop.rst_best) begin
            r_first <= 1'b1;
        end else if (r_rd_vld && !r_rd_peak) begin
            r_first <= 1'b0;
        end
        // Strict less-than keeps the lowest index on equal finish times.
        if (r_rd_vld && !r_rd_peak && (r_first || fin < r_best_fin)) begin
            r_best_fin <= fin;
            r_best_idx <= r_rd_idx;
        end
        if (r_rd_vld && r_rd_peak && load_rdata > r_peak) begin
            r_peak <= load_rdata;
        end
        if (uop.mul_en) begin
            r_prod <= prod;
        end
        if (uop.emit && out_free) begin
            r_out_data <= r_prod;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ejd_ram.sv
`default_nettype none

module ejd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ejd_checker.sv
`default_nettype none

module ejd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_axis_tvalid,
    input wire logic                          o_s_axis_tready,
    input wire logic                          i_s_axis_tlast,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [ejd_pkg::TOTAL_W-1:0]   o_m_axis_tdata
);

    logic last_xfer;
    logic body_xfer;

    assign last_xfer = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;
    assign body_xfer = i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tlast;

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_xfer |=> !o_s_axis_tready)
        else $error("input still ready after the final worker");

    a_list_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        body_xfer |=> o_s_axis_tready)
        else $error("input stalled in the middle of a worker list");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind earliest_finish_job_dispatch ejd_checker u_ejd_checker (.*);

`default_nettype wire

### bench/earliest_finish_job_dispatch_tb.sv
`default_nettype none

module earliest_finish_job_dispatch_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ejd_pkg::*;

    localparam int MAX_WORKERS   = 16;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    // Cycles allowed after the last result before the block is taken as idle.
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 1750;

    // ------------------------------------------------------------------
    // Clock, reset and the signals driven into the block. Every input has
    // a known value from time zero.
    // ------------------------------------------------------------------
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [TIME_W-1:0]     s_data  = '0;
    logic                  s_last  = 1'b0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [TOTAL_W-1:0]    m_data;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_JOB_COUNT;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    earliest_finish_job_dispatch #(
        .MAX_WORKERS(MAX_WORKERS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // job_time[15:0]
        .i_s_axis_tlast  (s_last),     // last_worker
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),     // total_time[39:0]
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: the worker list being collected, the two registers
    // as last written, and the totals still owed by the block, oldest first.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]   worker_times [MAX_WORKERS];
    int                  workers_held = 0;
    logic [JOBS_W-1:0]   job_limit    = '0;
    logic [MULT_W-1:0]   row_factor   = '0;
    logic [TOTAL_W-1:0]  pending_totals [$];

    int errors      = 0;
    int items_sent  = 0;

    // Sender pacing: bursts of random length separated by random gaps,
    // unless gaps are switched off for a stretch.
    bit gaps_on     = 1'b1;
    int burst_left  = 0;

    // Receiver pacing: a ready probability that changes from phase to
    // phase, plus a long hold-off that a test can request.
    int ready_pct   = 100;
    int phase_left  = 0;
    int hold_left   = 0;

    // Greedy earliest-finish dispatch over the workers held so far. Each job
    // goes to the worker with the smallest load plus job time; a strict
    // compare keeps ties on the lowest index. Returns makespan times factor.
    function automatic logic [TOTAL_W-1:0] predict_total();
        logic [LOAD_W-1:0] load [MAX_WORKERS];
        logic [FIN_W-1:0]  fin_best;
        logic [FIN_W-1:0]  fin_cand;
        logic [LOAD_W-1:0] peak;
        int                best;
        for (int w = 0; w < MAX_WORKERS; w++)
            load[w] = '0;
        for (int j = 0; j < int'(job_limit); j++) begin
            best = 0;
            for (int w = 1; w < workers_held; w++) begin
                fin_best = FIN_W'(load[best]) + FIN_W'(worker_times[best]);
                fin_cand = FIN_W'(load[w]) + FIN_W'(worker_times[w]);
                if (fin_best > fin_cand)
                    best = w;
            end
            load[best] = load[best] + LOAD_W'(worker_times[best]);
        end
        peak = '0;
        for (int w = 0; w < workers_held; w++)
            if (load[w] > peak)
                peak = load[w];
        return TOTAL_W'(peak) * TOTAL_W'(row_factor);
    endfunction

    // Called for every accepted worker transfer. Workers past the table size
    // are dropped, but a marked one still closes the list and starts a run.
    task automatic absorb_worker(input logic [TIME_W-1:0] t, input logic last);
        if (workers_held < MAX_WORKERS) begin
            worker_times[workers_held] = t;
            workers_held++;
        end
        if (last) begin
            pending_totals.insert(pending_totals.size(), predict_total());
            workers_held = 0;
        end
    endtask

    // Offers one worker transfer and returns once it has been accepted.
    // tvalid stays high afterwards, so back-to-back items never drop it.
    task automatic send_worker(input logic [TIME_W-1:0] t, input logic last);
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else if (burst_left > 0) begin
            burst_left--;
        end
        s_valid <= 1'b1;
        s_data  <= t;
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
        absorb_worker(t, last);
    endtask

    // Job times lean toward small values so that ties are common, with the
    // zero time and the largest time mixed in.
    function automatic logic [TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 6)
            return '1;
        if (r < 45)
            return TIME_W'($urandom_range(1, 8));
        return TIME_W'($urandom);
    endfunction

    task automatic send_list(input int n);
        for (int i = 0; i < n; i++)
            send_worker(pick_time(), i == n - 1);
    endtask

    // Drops tvalid and waits until every owed total has come back, then a
    // few more cycles so that the sequencer is back in its load step.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back; only called once the block is idle.
    task automatic set_config(input logic [JOBS_W-1:0] jobs,
                              input logic [MULT_W-1:0] mult);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_JOB_COUNT;
        cfg_data  <= CFG_DAT_W'(jobs);
        do @(posedge i_clk); while (!cfg_ready);
        job_limit = jobs;
        cfg_index <= CFG_ROW_MULT;
        cfg_data  <= CFG_DAT_W'(mult);
        do @(posedge i_clk); while (!cfg_ready);
        row_factor = mult;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: every accepted total is compared with the oldest owed
    // one, then tready is set for the next cycle.
    // ------------------------------------------------------------------
    task automatic check_total(input logic [TOTAL_W-1:0] got);
        logic [TOTAL_W-1:0] want;
        if (pending_totals.size() == 0) begin
            $error("total_time: no result expected, actual %0d", got);
            errors++;
        end else begin
            want = pending_totals.pop_front();
            if (got !== want) begin
                $error("total_time mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_valid && m_ready)
                check_total(m_data);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                    phase_left = $urandom_range(20, 300);
                end
                phase_left--;
                m_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Both registers come out of reset at zero, so any list must total zero.
    task automatic test_reset_values();
        send_worker(16'd9, 1'b1);
    endtask

    // A single slowest worker takes every job of the largest job count, and
    // the largest factor gives the largest total the block can produce.
    task automatic test_extremes();
        set_config('1, '1);
        send_worker('1, 1'b1);
    endtask

    // With no jobs every load stays zero, whatever the factor.
    task automatic test_no_jobs();
        set_config('0, '1);
        send_worker(16'h8001, 1'b0);
        send_worker(16'h7ffe, 1'b1);
    endtask

    // Equal times spread jobs round-robin from the lowest index; a worker
    // with a zero job time finishes at its current load and takes every job.
    task automatic test_ties_and_zero_time();
        set_config(12'd7, 12'd1);
        send_worker(16'd3, 1'b0);
        send_worker(16'd3, 1'b0);
        send_worker(16'd3, 1'b1);
        send_worker(16'd2, 1'b0);
        send_worker(16'd0, 1'b0);
        send_worker(16'd1, 1'b1);
    endtask

    // One more worker than the table holds, marked on the dropped item: the
    // run goes over the full table, here with the largest job count.
    task automatic test_worker_overflow();
        set_config('1, 12'd4093);
        for (int i = 0; i <= MAX_WORKERS; i++) begin
            if (i == 0)
                send_worker('1, 1'b0);
            else if (i == 1)
                send_worker(16'd1, 1'b0);
            else
                send_worker(TIME_W'($urandom), i == MAX_WORKERS);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps going:
    // one total sits in the output register, the next run waits on it, and
    // the worker channel stops accepting. Then the sender pauses until all
    // totals have drained.
    task automatic test_backpressure();
        set_config(12'd3, 12'd5);
        gaps_on = 1'b0;
        hold_left = 2000;
        for (int r = 0; r < 5; r++)
            send_list($urandom_range(2, 5));
        settle();
        gaps_on = 1'b1;
    endtask

    // Random worker lists in phases, each with its own register settings and
    // sender pacing. Most lists are well formed; a few run past the table.
    task automatic test_random_lists();
        int          r;
        int          runs;
        int          max_n;
        logic [11:0] jobs;
        logic [11:0] mult;
        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                jobs = '0;
            else if (r < 80)
                jobs = 12'($urandom_range(1, 24));
            else if (r < 95)
                jobs = 12'($urandom_range(25, 150));
            else
                jobs = 12'($urandom_range(500, 4095));
            r = $urandom_range(0, 9);
            mult = (r == 0) ? '0 : (r == 1) ? '1 : 12'($urandom);
            set_config(jobs, mult);
            gaps_on = ($urandom_range(0, 3) != 0);
            // Large job counts make each run long, so keep those lists short.
            runs  = (jobs > 200) ? 2 : $urandom_range(8, 20);
            max_n = (jobs > 200) ? 3 : MAX_WORKERS;
            for (int k = 0; k < runs; k++) begin
                if (max_n == MAX_WORKERS && $urandom_range(0, 19) == 0)
                    send_list($urandom_range(MAX_WORKERS + 1, MAX_WORKERS + 8));
                else
                    send_list($urandom_range(1, max_n));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_extremes();
        test_no_jobs();
        test_ties_and_zero_time();
        test_worker_overflow();
        test_backpressure();
        test_random_lists();

        settle();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run including the long
    // dispatch over a full table with the largest job count.
    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
